// File: hdl/pls_pkg.sv
// Shared types, codes and defaults for the positional list store.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

	localparam int PLS_CAPACITY  = 64;
	localparam int PLS_WORD_BITS = 32;

	// operation codes carried in the mode field
	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_DELETE = 3'd1;
	localparam logic [2:0] MODE_GET    = 3'd2;
	localparam logic [2:0] MODE_FIND   = 3'd3;
	localparam logic [2:0] MODE_PREV   = 3'd4;
	localparam logic [2:0] MODE_CLEAR  = 3'd5;

	typedef struct packed {
		logic [2:0]         mode;
		logic [6:0]         position;
		logic signed [31:0] value;
	} pls_req_t;

	typedef struct packed {
		logic               status;
		logic signed [31:0] out_value;
		logic [6:0]         found_position;
		logic [6:0]         length_now;
		logic               is_empty;
	} pls_rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic [2:0] mode;
		logic [6:0] position;
		logic       ins_we;
		logic       del_we;
	} pls_ctl_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic        active;
		logic        done;
		logic        ok;
		logic [31:0] out_value;
		logic [6:0]  found_position;
	} pls_probe_t;

endpackage

`default_nettype wire

// File: hdl/pls_cell.sv
// One list slot: holds an entry, shifts with its neighbors, serves the search token.
`timescale 1ns / 1ps
`default_nettype none

module pls_cell #(
	parameter int WORD_BITS = 32,
	parameter int CNT_W     = 7,
	parameter int INDEX     = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pls_pkg::pls_ctl_t      ctl,
	input  wire logic [WORD_BITS-1:0]   key,
	input  wire logic [CNT_W-1:0]       count,
	input  wire logic [WORD_BITS-1:0]   left_word,
	input  wire logic [WORD_BITS-1:0]   right_word,
	input  wire pls_pkg::pls_probe_t    probe_in,
	output logic [WORD_BITS-1:0]        word,
	output pls_pkg::pls_probe_t         probe_out
);
	import pls_pkg::*;

	logic [WORD_BITS-1:0] word_q;
	logic [31:0]          own_ext;
	logic [31:0]          left_ext;
	logic                 live;
	logic                 pos_hit;
	logic                 key_hit;
	pls_probe_t           probe_d;
	pls_probe_t           probe_q;

	// sign-extend or truncate stored words to the 32-bit result field
	if (WORD_BITS >= 32) begin : g_trunc
		assign own_ext  = word_q[31:0];
		assign left_ext = left_word[31:0];
	end else begin : g_ext
		assign own_ext  = {{(32-WORD_BITS){word_q[WORD_BITS-1]}}, word_q};
		assign left_ext = {{(32-WORD_BITS){left_word[WORD_BITS-1]}}, left_word};
	end

	assign live    = CNT_W'(INDEX) < count;
	assign pos_hit = (int'(ctl.position) == INDEX + 1);
	assign key_hit = (word_q == key);

	// entry shifting
	always_ff @(posedge clk) begin
		if (ctl.ins_we) begin
			if (int'(ctl.position) == INDEX + 1) begin
				word_q <= key;
			end else if (INDEX + 1 > int'(ctl.position) && CNT_W'(INDEX) <= count) begin
				word_q <= left_word;
			end
		end else if (ctl.del_we) begin
			if (INDEX + 1 >= int'(ctl.position) && CNT_W'(INDEX + 1) < count) begin
				word_q <= right_word;
			end
		end
	end

	always_comb begin
		probe_d = probe_in;
		if (probe_in.active && !probe_in.done) begin
			if (!live) begin
				probe_d.done = 1'b1;
			end else begin
				unique case (ctl.mode)
					MODE_GET, MODE_DELETE: begin
						if (pos_hit) begin
							probe_d.done      = 1'b1;
							probe_d.ok        = 1'b1;
							probe_d.out_value = own_ext;
						end
					end
					MODE_FIND: begin
						if (key_hit) begin
							probe_d.done           = 1'b1;
							probe_d.ok             = 1'b1;
							probe_d.found_position = 7'(INDEX + 1);
						end
					end
					MODE_PREV: begin
						if (key_hit) begin
							probe_d.done = 1'b1;
							if (INDEX >= 1) begin
								probe_d.ok        = 1'b1;
								probe_d.out_value = left_ext;
							end
						end
					end
					default: begin
						probe_d.done = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	assign word      = word_q;
	assign probe_out = probe_q;

endmodule

`default_nettype wire

// File: hdl/positional_list_store_unit.sv
// Top level of the positional list store: controller, cell row, result register.
//
// Usage:
//   req channel (req_valid/req_ready/req_word) carries one operation word:
//   insert, delete, get, find, previous or clear. rsp channel
//   (rsp_valid/rsp_ready/rsp_word) returns exactly one result word per request.
//   Entries live in a row of CAPACITY cells; insert and delete shift all
//   cells from the given position on together.
//   Sequence: insert, clear and unused codes finish in the execute state and
//   load the result register. Get, delete, find and previous send a search
//   token down the cell row one cell per cycle; the result is collected when
//   the token leaves the last cell.
//   Flow: one request in flight at a time, so a new word is taken only once
//   the previous result has moved into the output register.
//   Reset (arst_n low) empties the list and drops any pending word; stored
//   entries keep stale data but are out of the list.
//   Stall: while rsp_ready is low the finished result sits in the output
//   register; the block still takes and processes the next request and holds
//   its result until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_unit #(
	parameter int CAPACITY  = pls_pkg::PLS_CAPACITY,
	parameter int WORD_BITS = pls_pkg::PLS_WORD_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire pls_pkg::pls_req_t req_word,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output pls_pkg::pls_rsp_t      rsp_word
);
	import pls_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PC_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	pls_req_t             cmd_q;
	pls_rsp_t             res_q, res_d;
	pls_rsp_t             rsp_q;
	logic                 rsp_valid_q;
	logic                 res_ld;
	logic                 rsp_load;
	logic [WORD_BITS-1:0] key;
	pls_ctl_t             ctl;
	pls_probe_t           launch;
	pls_probe_t           tail;
	logic                 scan_mode;
	logic                 ins_ok;
	logic [PC_W-1:0]      pos_x;
	logic [PC_W-1:0]      cnt_x;

	logic [WORD_BITS-1:0] words  [CAPACITY];
	pls_probe_t           probes [CAPACITY];

	// search key: the low WORD_BITS of the signed value, or its sign extension when WORD_BITS is above 32
	if (WORD_BITS <= 32) begin : g_key_trunc
		assign key = cmd_q.value[WORD_BITS-1:0];
	end else begin : g_key_ext
		assign key = {{(WORD_BITS-32){cmd_q.value[31]}}, cmd_q.value};
	end

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] lw;
		logic [WORD_BITS-1:0] rw;
		pls_probe_t           pin;

		if (i == 0) begin : g_head
			assign lw  = '0;
			assign pin = launch;
		end else begin : g_body
			assign lw  = words[i-1];
			assign pin = probes[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rw = '0;
		end else begin : g_inner
			assign rw = words[i+1];
		end

		pls_cell #(
			.WORD_BITS(WORD_BITS),
			.CNT_W    (CNT_W),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key       (key),
			.count     (count_q),
			.left_word (lw),
			.right_word(rw),
			.probe_in  (pin),
			.word      (words[i]),
			.probe_out (probes[i])
		);
	end

	assign tail = probes[CAPACITY-1];

	assign scan_mode = (cmd_q.mode == MODE_DELETE) || (cmd_q.mode == MODE_GET) ||
	                   (cmd_q.mode == MODE_FIND)   || (cmd_q.mode == MODE_PREV);

	// insert is legal at 1..length+1 and only below capacity
	assign pos_x  = PC_W'(cmd_q.position);
	assign cnt_x  = PC_W'(count_q);
	assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + PC_W'(1)) &&
	                (count_q < CNT_W'(CAPACITY));

	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		ctl.mode        = cmd_q.mode;
		ctl.position    = cmd_q.position;
		ctl.ins_we      = 1'b0;
		ctl.del_we      = 1'b0;
		launch          = '0;
		res_ld          = 1'b0;
		res_d           = '0;
		res_d.status    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (scan_mode) begin
					// token enters cell 0 this cycle
					launch.active = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					res_ld  = 1'b1;
					state_d = ST_DONE;
					if (cmd_q.mode == MODE_INSERT) begin
						if (ins_ok) begin
							ctl.ins_we   = 1'b1;
							count_d      = count_q + CNT_W'(1);
							res_d.status = 1'b0;
						end
					end else if (cmd_q.mode == MODE_CLEAR) begin
						count_d      = '0;
						res_d.status = 1'b0;
					end
				end
			end
			ST_SCAN: begin
				// token leaves the last cell: collect and, for delete, close the gap
				if (tail.active) begin
					res_ld               = 1'b1;
					state_d              = ST_DONE;
					res_d.status         = !(tail.done && tail.ok);
					res_d.out_value      = tail.out_value;
					res_d.found_position = tail.found_position;
					if (cmd_q.mode == MODE_DELETE && tail.done && tail.ok) begin
						ctl.del_we = 1'b1;
						count_d    = count_q - CNT_W'(1);
					end
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res_d.length_now = 7'(count_d);
		res_d.is_empty   = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= req_word;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// length never exceeds the cell count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list length above capacity");

	// the token reaches the end of the row only during a scan
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> state_q == ST_SCAN)
		else $error("search token outside a scan");

	// clear empties the list
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && cmd_q.mode == MODE_CLEAR) |=> count_q == '0)
		else $error("clear left entries");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the positional list store: directed table, then random words.
`timescale 1ns / 1ps

module testbench;
	import pls_pkg::*;

	// Operation codes with no defined behavior; the block must answer them with an error.
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam logic       STAT_OK       = 1'b0;
	localparam logic       STAT_ERR      = 1'b1;

	localparam int RANDOM_OPS   = 1000;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 500000;

	// One row of the directed table.
	// fixed = 1: the expected result is typed into the row.
	// fixed = 0: the expected result comes from the shadow list.
	// reps repeats the row, adding the repeat index to the value each time.
	typedef struct {
		pls_req_t req;
		int       reps;
		bit       fixed;
		pls_rsp_t rsp;
	} step_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	pls_req_t req_word  = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	pls_rsp_t rsp_word;

	// Shadow copy of the list. The predictor updates it once per accepted request word.
	logic signed [31:0] shadow_words [0:PLS_CAPACITY-1];
	int                 shadow_len;

	// Expected result words, oldest first.
	pls_rsp_t awaited_rsp [$];
	step_t    directed_steps [$];
	int       mismatch_count = 0;
	int       cycle_count    = 0;

	// Flags the stimulus sets for the other processes.
	// calm: neither side idles.
	// hold_now: the receiver starts its long hold-off.
	bit calm     = 1'b0;
	bit hold_now = 1'b0;

	positional_list_store_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one operation to the shadow list and return the result the block must give.
	function automatic pls_rsp_t list_op_result(input pls_req_t r);
		pls_rsp_t res;
		int       p;
		int       k;
		int       hit;
		res = '0;
		res.status = STAT_ERR;
		p = int'(r.position);
		hit = -1;
		// First match of the search value; find and previous both use it.
		for (k = 0; k < shadow_len; k++) begin
			if (hit < 0 && shadow_words[k] == r.value)
				hit = k;
		end
		case (r.mode)
			MODE_INSERT: begin
				// The position may be one past the tail. A full list refuses every insert.
				if (p >= 1 && p <= shadow_len + 1 && shadow_len < PLS_CAPACITY) begin
					for (k = shadow_len; k > p - 1; k--)
						shadow_words[k] = shadow_words[k - 1];
					shadow_words[p - 1] = r.value;
					shadow_len++;
					res.status = STAT_OK;
				end
			end
			MODE_DELETE: begin
				if (p >= 1 && p <= shadow_len) begin
					res.out_value = shadow_words[p - 1];
					for (k = p - 1; k < shadow_len - 1; k++)
						shadow_words[k] = shadow_words[k + 1];
					shadow_len--;
					res.status = STAT_OK;
				end
			end
			MODE_GET: begin
				if (p >= 1 && p <= shadow_len) begin
					res.out_value = shadow_words[p - 1];
					res.status = STAT_OK;
				end
			end
			MODE_FIND: begin
				if (hit >= 0) begin
					res.found_position = 7'(hit + 1);
					res.status = STAT_OK;
				end
			end
			MODE_PREV: begin
				// A match at the head has no word before it.
				if (hit >= 1) begin
					res.out_value = shadow_words[hit - 1];
					res.status = STAT_OK;
				end
			end
			MODE_CLEAR: begin
				shadow_len = 0;
				res.status = STAT_OK;
			end
			default: ;
		endcase
		res.length_now = 7'(shadow_len);
		res.is_empty = (shadow_len == 0);
		return res;
	endfunction

	task automatic add_row(input logic [2:0] mode, input logic [6:0] pos,
			input logic signed [31:0] val, input int reps, input bit fixed,
			input logic st, input logic signed [31:0] ov, input logic [6:0] fp,
			input logic [6:0] ln);
		step_t s;
		s.req.mode = mode;
		s.req.position = pos;
		s.req.value = val;
		s.reps = reps;
		s.fixed = fixed;
		s.rsp.status = st;
		s.rsp.out_value = ov;
		s.rsp.found_position = fp;
		s.rsp.length_now = ln;
		s.rsp.is_empty = (ln == 0);
		directed_steps.push_back(s);
	endtask

	// Offer one request word and hold it until it is accepted.
	// On acceptance the expected result is queued.
	// The task is entered and left right after a rising edge.
	task automatic offer(input pls_req_t w, input bit fixed, input pls_rsp_t fixed_rsp);
		pls_rsp_t model_rsp;
		int       gap;
		if (!calm && $urandom_range(0, 99) < 23) begin
			// Short gaps are the usual case. A longer gap sometimes lands mid-search.
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		model_rsp = list_op_result(w);
		awaited_rsp.push_back(fixed ? fixed_rsp : model_rsp);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Response monitor. Each accepted result word is compared with the oldest expected word.
	always @(posedge clk) begin : rsp_check
		pls_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				$display("%0t: result word with none expected, got %0h", $time, rsp_word);
				mismatch_count++;
			end else begin
				want = awaited_rsp.pop_front();
				check_field("status", want.status, rsp_word.status);
				check_field("out_value", want.out_value, rsp_word.out_value);
				check_field("found_position", want.found_position, rsp_word.found_position);
				check_field("length_now", want.length_now, rsp_word.length_now);
				check_field("is_empty", want.is_empty, rsp_word.is_empty);
			end
		end
	end

	// Result receiver. It idles now and then.
	// One long hold-off, counted here, fills the block so that req_ready drops.
	initial begin : sink
		int  hold_left;
		bit  hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_now && !hold_taken) begin
				hold_left = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (calm) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= 23);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		pls_req_t w;
		pls_rsp_t none;
		step_t    s;
		int       n;
		int       rep;
		int       roll;
		bit       grow;

		none = '0;
		shadow_len = 0;
		for (n = 0; n < PLS_CAPACITY; n++)
			shadow_words[n] = '0;

		// Empty list: every read fails and position 0 never fits.
		add_row(MODE_GET,      7'd1,   32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 0);
		add_row(MODE_DELETE,   7'd0,   32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 0);
		add_row(MODE_FIND,     7'd0,   32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 0);
		add_row(MODE_PREV,     7'd0,   32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 0);
		add_row(MODE_INSERT,   7'd0,   32'sd9,          1, 1'b1, STAT_ERR, 0, 0, 0);
		add_row(MODE_INSERT,   7'd2,   32'sd9,          1, 1'b1, STAT_ERR, 0, 0, 0);
		// Build the list 8000_0000, 7fff_ffff, 0.
		add_row(MODE_INSERT,   7'd1,   32'sh7fffffff,   1, 1'b1, STAT_OK,  0, 0, 1);
		add_row(MODE_INSERT,   7'd1,   32'sh80000000,   1, 1'b1, STAT_OK,  0, 0, 2);
		add_row(MODE_INSERT,   7'd3,   32'sd0,          1, 1'b1, STAT_OK,  0, 0, 3);
		add_row(MODE_INSERT,   7'd5,   32'sd1,          1, 1'b1, STAT_ERR, 0, 0, 3);
		add_row(MODE_GET,      7'd1,   32'sd0,          1, 1'b1, STAT_OK,  32'sh80000000, 0, 3);
		add_row(MODE_GET,      7'd2,   32'sd0,          1, 1'b1, STAT_OK,  32'sh7fffffff, 0, 3);
		add_row(MODE_GET,      7'd4,   32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 3);
		add_row(MODE_GET,      7'd127, 32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 3);
		add_row(MODE_FIND,     7'd0,   32'sh80000000,   1, 1'b1, STAT_OK,  0, 1, 3);
		add_row(MODE_FIND,     7'd0,   32'sd0,          1, 1'b1, STAT_OK,  0, 3, 3);
		// A match at the head has no predecessor.
		add_row(MODE_PREV,     7'd0,   32'sh80000000,   1, 1'b1, STAT_ERR, 0, 0, 3);
		add_row(MODE_PREV,     7'd0,   32'sd0,          1, 1'b1, STAT_OK,  32'sh7fffffff, 0, 3);
		add_row(MODE_FIND,     7'd0,   32'sd12345,      1, 1'b1, STAT_ERR, 0, 0, 3);
		add_row(MODE_SPARE_LO, 7'd1,   32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 3);
		add_row(MODE_SPARE_HI, 7'd127, -32'sd1,         1, 1'b1, STAT_ERR, 0, 0, 3);
		add_row(MODE_DELETE,   7'd2,   32'sd0,          1, 1'b1, STAT_OK,  32'sh7fffffff, 0, 2);
		add_row(MODE_DELETE,   7'd3,   32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 2);
		add_row(MODE_CLEAR,    7'd0,   32'sd0,          1, 1'b1, STAT_OK,  0, 0, 0);
		add_row(MODE_GET,      7'd1,   32'sd0,          1, 1'b1, STAT_ERR, 0, 0, 0);
		// Fill to capacity by head inserts.
		// The list then reads 163 .. 100, and every further insert fails.
		add_row(MODE_INSERT,   7'd1,   32'sd100,       64, 1'b0, STAT_OK,  0, 0, 0);
		add_row(MODE_INSERT,   7'd1,   32'sd7,          1, 1'b1, STAT_ERR, 0, 0, 64);
		add_row(MODE_INSERT,   7'd65,  32'sd7,          1, 1'b1, STAT_ERR, 0, 0, 64);
		add_row(MODE_GET,      7'd64,  32'sd0,          1, 1'b1, STAT_OK,  32'sd100, 0, 64);
		add_row(MODE_DELETE,   7'd64,  32'sd0,          1, 1'b1, STAT_OK,  32'sd100, 0, 63);
		add_row(MODE_INSERT,   7'd64,  -32'sd5,         1, 1'b1, STAT_OK,  0, 0, 64);
		add_row(MODE_FIND,     7'd0,   -32'sd5,         1, 1'b1, STAT_OK,  0, 64, 64);
		add_row(MODE_PREV,     7'd0,   -32'sd5,         1, 1'b0, STAT_OK,  0, 0, 0);
		add_row(MODE_CLEAR,    7'd0,   32'sd0,          1, 1'b1, STAT_OK,  0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			s = directed_steps[i];
			for (rep = 0; rep < s.reps; rep++) begin
				w = s.req;
				w.value = s.req.value + rep;
				offer(w, s.fixed, s.rsp);
			end
		end

		// Random part.
		// The mix alternates between a growing phase and a shrinking phase, so that
		// the list runs from empty up to full. Positions are mostly in range.
		// Search values are mostly taken from the list.
		for (n = 0; n < RANDOM_OPS; n++) begin
			grow = ((n / 120) % 2 == 0);
			calm = (n >= 500 && n < 700);
			if (n == 300)
				hold_now = 1'b1;
			if (n == 800) begin
				// Drain completely before going on.
				req_valid <= 1'b0;
				do
					@(posedge clk);
				while (awaited_rsp.size() != 0);
			end

			roll = $urandom_range(0, 99);
			if (grow) begin
				w.mode = (roll < 58) ? MODE_INSERT : (roll < 66) ? MODE_DELETE :
					(roll < 78) ? MODE_GET : (roll < 87) ? MODE_FIND :
					(roll < 96) ? MODE_PREV : (roll < 97) ? MODE_CLEAR :
					($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO);
			end else begin
				w.mode = (roll < 15) ? MODE_INSERT : (roll < 55) ? MODE_DELETE :
					(roll < 70) ? MODE_GET : (roll < 80) ? MODE_FIND :
					(roll < 92) ? MODE_PREV : (roll < 94) ? MODE_CLEAR :
					($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO);
			end

			if ($urandom_range(0, 99) < 88) begin
				if (w.mode == MODE_INSERT)
					w.position = 7'($urandom_range(1, shadow_len + 1));
				else
					w.position = 7'((shadow_len > 0) ? $urandom_range(1, shadow_len) : 1);
			end else begin
				w.position = 7'($urandom_range(0, 127));
			end

			roll = $urandom_range(0, 99);
			if ((w.mode == MODE_FIND || w.mode == MODE_PREV) && shadow_len > 0 && roll < 70)
				w.value = shadow_words[$urandom_range(0, shadow_len - 1)];
			else if (roll < 40)
				// Small values repeat often, so lists hold duplicates.
				w.value = $urandom_range(0, 15) - 8;
			else if (roll < 50)
				w.value = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			else
				w.value = $urandom();

			offer(w, 1'b0, none);
		end

		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (PLS_CAPACITY + 8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
